// File: hdl/doubly_linked_list_engine_assert.svh
// Assertion macros for the doubly linked list engine.
// Used by the RTL files that carry concurrent checks; no dependencies.
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define DLLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dlle check failed");
`define DLLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `DLLE_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`else
`define DLLE_ASSERT(lbl, clk, rst_n, prop)
`define DLLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/dlle_pkg.sv
// Shared types and constants of the doubly linked list engine.
// No dependencies; imported by every module of the block except dlle_ram.
`default_nettype none

package dlle_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int HANDLE_W   = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;

  localparam int WALK_MAX = 16;
  localparam int WALK_W   = 5;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEL_HEAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_TAIL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ERASE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WALK_FWD  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_WALK_REV  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd7;

  typedef enum logic [MODE_W-1:0] {
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_DEL_HEAD,
    OP_DEL_TAIL,
    OP_ERASE,
    OP_WALK_FWD,
    OP_WALK_REV,
    OP_CLEAR
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_EMPTY,
    STAT_FULL,
    STAT_BAD_HANDLE
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHORT,
    S_INS_LINK,
    S_RM_LINK,
    S_WALK
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [VALUE_W-1:0]  value;
    logic [HANDLE_W-1:0] handle;
    logic                handle_ok;
  } item_t;

endpackage

`default_nettype wire

// File: hdl/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine: front end with item queue and
// back end with slot pool and link RAMs. Depends on dlle_pkg, dlle_front, dlle_back.
//
// Channel  Dir  Handshake             Beat payload
// in       in   in_valid / in_ready   in_mode, in_value, in_node_handle
// out      out  out_valid / out_ready out_value_out, out_slot_out, out_count,
//                                     out_status, out_last
//
// A beat waits in the two-entry queue until the executor pops it in its idle state; inserts,
// deletes, erases, clear and errors then pass through a link or short state that loads the
// result register before the executor returns to idle. A walk of n nodes holds the executor
// in its walk state, one node per cycle while the out channel is free, through the shared
// read port of the data and link RAMs. Reset is synchronous and active low; it empties the
// list and the queue, and the RAMs need no clearing since only used slots are read.
// A stalled out channel holds the executor, while the queue still takes up to two beats.
`default_nettype none

module doubly_linked_list_engine #(
  parameter int CAPACITY   = dlle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dlle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [dlle_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [dlle_pkg::VALUE_W-1:0]    in_value,
  input  wire logic [dlle_pkg::HANDLE_W-1:0]   in_node_handle,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [dlle_pkg::VALUE_W-1:0]         out_value_out,
  output logic [dlle_pkg::SLOT_OUT_W-1:0]      out_slot_out,
  output logic [dlle_pkg::COUNT_W-1:0]         out_count,
  output logic [dlle_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_last
);
  import dlle_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  dlle_front #(.CAPACITY(CAPACITY)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_node_handle (in_node_handle),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item)
  );

  dlle_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_out (out_value_out),
    .out_slot_out  (out_slot_out),
    .out_count     (out_count),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// File: hdl/dlle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the node data and link arrays of the engine.
`default_nettype none

module dlle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/dlle_front.sv
// Front end: accepts input beats, decodes the mode, range-checks the handle
// and holds the classified items in a short queue. Depends on dlle_pkg.
`default_nettype none

module dlle_front #(
  parameter int CAPACITY = dlle_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dlle_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [dlle_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [dlle_pkg::HANDLE_W-1:0] in_node_handle,
  output logic                               q_valid,
  input  wire logic                          q_ready,
  output dlle_pkg::item_t                    q_item
);
  import dlle_pkg::*;

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  item_t          item_in;
  op_t            op_dec;
  item_t          mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;
  logic           push, pop;

  always_comb begin
    unique case (in_mode)
      MODE_INS_FRONT: op_dec = OP_INS_FRONT;
      MODE_INS_BACK:  op_dec = OP_INS_BACK;
      MODE_DEL_HEAD:  op_dec = OP_DEL_HEAD;
      MODE_DEL_TAIL:  op_dec = OP_DEL_TAIL;
      MODE_ERASE:     op_dec = OP_ERASE;
      MODE_WALK_FWD:  op_dec = OP_WALK_FWD;
      MODE_WALK_REV:  op_dec = OP_WALK_REV;
      MODE_CLEAR:     op_dec = OP_CLEAR;
      default:        op_dec = OP_CLEAR;
    endcase
  end

  always_comb begin
    item_in.op        = op_dec;
    item_in.value     = in_value;
    item_in.handle    = in_node_handle;
    item_in.handle_ok = int'(in_node_handle) < CAPACITY;
  end

  assign in_ready = fill_r != QCW'(QUEUE_DEPTH);
  assign q_valid  = fill_r != '0;
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + QCW'(1);
      2'b01:   fill_nxt = fill_r - QCW'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dlle_back.sv
// Back end: executes queued items against the slot pool, the link RAMs and
// the list registers, and drives the result register. Depends on dlle_pkg,
// dlle_ram and the assertion macro header.
`default_nettype none
`include "doubly_linked_list_engine_assert.svh"

module dlle_back #(
  parameter int CAPACITY   = dlle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dlle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  output logic                                 q_ready,
  input  wire dlle_pkg::item_t                 q_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [dlle_pkg::VALUE_W-1:0]         out_value_out,
  output logic [dlle_pkg::SLOT_OUT_W-1:0]      out_slot_out,
  output logic [dlle_pkg::COUNT_W-1:0]         out_count,
  output logic [dlle_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_last
);
  import dlle_pkg::*;

  localparam int SW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > WALK_W) ? CW : WALK_W;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  status_t               status_r, status_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [WALK_W-1:0]     remain_r, remain_nxt;
  logic [CAPACITY-1:0]   used_r, used_nxt;
  logic [SW-1:0]         head_r, head_nxt;
  logic [SW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_re;
  logic [SW-1:0]         ram_raddr;
  logic                  data_we;
  logic [SW-1:0]         data_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic                  nxt_we;
  logic [SW-1:0]         nxt_waddr;
  logic [SW-1:0]         nxt_wdata;
  logic                  prv_we;
  logic [SW-1:0]         prv_waddr;
  logic [SW-1:0]         prv_wdata;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [SW-1:0]         rd_next;
  logic [SW-1:0]         rd_prev;

  logic                  ofree;
  logic                  is_full, is_empty;
  logic [SW-1:0]         free_slot;
  logic [SW-1:0]         hslot;
  logic [SW-1:0]         first_slot;
  logic [SW-1:0]         walk_link;
  logic [CMPW-1:0]       cnt_w;
  logic [WALK_W-1:0]     walk_n;
  logic [CW-1:0]         cnt_inc, cnt_dec;
  logic [VALUE_W-1:0]    rd_value;
  logic                  pop_short;
  status_t               pop_status;

  dlle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  dlle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_next)
  );

  dlle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_prev)
  );

  assign ofree     = !out_valid_r || out_ready;
  assign is_full   = cnt_r == CW'(CAPACITY);
  assign is_empty  = cnt_r == '0;
  assign hslot     = SW'(q_item.handle);
  assign cnt_inc   = cnt_r + CW'(1);
  assign cnt_dec   = cnt_r - CW'(1);
  assign rd_value  = VALUE_W'($signed(rd_data));
  assign walk_link = (op_r == OP_WALK_FWD) ? rd_next : rd_prev;
  assign cnt_w     = CMPW'(cnt_r);
  assign walk_n    = (cnt_w > CMPW'(WALK_MAX)) ? WALK_W'(WALK_MAX) : WALK_W'(cnt_w);

  always_comb begin
    free_slot = SW'(CAPACITY - 1);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    case (q_item.op) inside
      OP_DEL_HEAD, OP_WALK_FWD: first_slot = head_r;
      OP_ERASE:                 first_slot = hslot;
      default:                  first_slot = tail_r;
    endcase
  end

  always_comb begin
    unique case (q_item.op) inside
      OP_INS_FRONT, OP_INS_BACK: begin
        pop_short  = is_full;
        pop_status = is_full ? STAT_FULL : STAT_OK;
      end
      OP_DEL_HEAD, OP_DEL_TAIL, OP_WALK_FWD, OP_WALK_REV: begin
        pop_short  = is_empty;
        pop_status = is_empty ? STAT_EMPTY : STAT_OK;
      end
      OP_ERASE: begin
        pop_short  = !q_item.handle_ok || !used_r[hslot];
        pop_status = pop_short ? STAT_BAD_HANDLE : STAT_OK;
      end
      default: begin
        pop_short  = 1'b1;
        pop_status = STAT_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (pop_short) begin
            state_nxt = S_SHORT;
          end else begin
            case (q_item.op) inside
              OP_INS_FRONT, OP_INS_BACK: state_nxt = S_INS_LINK;
              OP_WALK_FWD, OP_WALK_REV:  state_nxt = S_WALK;
              default:                   state_nxt = S_RM_LINK;
            endcase
          end
        end
      end
      S_SHORT, S_INS_LINK, S_RM_LINK: begin
        if (ofree) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (ofree && remain_r == WALK_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_ready        = 1'b0;
    op_nxt         = op_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    remain_nxt     = remain_r;
    used_nxt       = used_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_re         = 1'b0;
    ram_raddr      = first_slot;
    data_we        = 1'b0;
    data_waddr     = free_slot;
    data_wdata     = DATA_WIDTH'($signed(q_item.value));
    nxt_we         = 1'b0;
    nxt_waddr      = free_slot;
    nxt_wdata      = free_slot;
    prv_we         = 1'b0;
    prv_waddr      = free_slot;
    prv_wdata      = free_slot;

    unique case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          op_nxt     = q_item.op;
          status_nxt = pop_status;
          if (!pop_short) begin
            case (q_item.op) inside
              OP_INS_FRONT, OP_INS_BACK: begin
                slot_nxt = free_slot;
                data_we  = 1'b1;
                nxt_we   = 1'b1;
                prv_we   = 1'b1;
                if (q_item.op == OP_INS_FRONT && !is_empty) begin
                  nxt_wdata = head_r;
                end
                if (q_item.op == OP_INS_BACK && !is_empty) begin
                  prv_wdata = tail_r;
                end
              end
              default: begin
                slot_nxt   = first_slot;
                ram_re     = 1'b1;
                remain_nxt = walk_n;
              end
            endcase
          end
        end
      end
      S_SHORT: begin
        if (ofree) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_slot_nxt   = '0;
          out_count_nxt  = COUNT_W'(cnt_r);
          out_status_nxt = status_r;
          out_last_nxt   = 1'b1;
          if (op_r == OP_CLEAR) begin
            used_nxt      = '0;
            head_nxt      = '0;
            tail_nxt      = '0;
            cnt_nxt       = '0;
            out_count_nxt = '0;
          end
        end
      end
      S_INS_LINK: begin
        if (ofree) begin
          if (is_empty) begin
            head_nxt = slot_r;
            tail_nxt = slot_r;
          end else if (op_r == OP_INS_FRONT) begin
            prv_we    = 1'b1;
            prv_waddr = head_r;
            prv_wdata = slot_r;
            head_nxt  = slot_r;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = tail_r;
            nxt_wdata = slot_r;
            tail_nxt  = slot_r;
          end
          used_nxt[slot_r] = 1'b1;
          cnt_nxt          = cnt_inc;
          out_valid_nxt    = 1'b1;
          out_value_nxt    = '0;
          out_slot_nxt     = SLOT_OUT_W'(slot_r);
          out_count_nxt    = COUNT_W'(cnt_inc);
          out_status_nxt   = STAT_OK;
          out_last_nxt     = 1'b1;
        end
      end
      S_RM_LINK: begin
        if (ofree) begin
          if (cnt_r <= CW'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else if (slot_r == head_r) begin
            head_nxt = rd_next;
          end else if (slot_r == tail_r) begin
            tail_nxt = rd_prev;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = rd_prev;
            nxt_wdata = rd_next;
            prv_we    = 1'b1;
            prv_waddr = rd_next;
            prv_wdata = rd_prev;
          end
          used_nxt[slot_r] = 1'b0;
          cnt_nxt          = cnt_dec;
          out_valid_nxt    = 1'b1;
          out_value_nxt    = rd_value;
          out_slot_nxt     = SLOT_OUT_W'(slot_r);
          out_count_nxt    = COUNT_W'(cnt_dec);
          out_status_nxt   = STAT_OK;
          out_last_nxt     = 1'b1;
        end
      end
      S_WALK: begin
        if (ofree) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_value;
          out_slot_nxt   = SLOT_OUT_W'(slot_r);
          out_count_nxt  = COUNT_W'(cnt_r);
          out_status_nxt = STAT_OK;
          out_last_nxt   = remain_r == WALK_W'(1);
          if (remain_r != WALK_W'(1)) begin
            slot_nxt   = walk_link;
            ram_re     = 1'b1;
            ram_raddr  = walk_link;
            remain_nxt = remain_r - WALK_W'(1);
          end
        end
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    remain_r     <= remain_nxt;
    out_value_r  <= out_value_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_slot_out  = out_slot_r;
  assign out_count     = out_count_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  `DLLE_ASSERT(a_count_matches_used, clk, rst_n, $countones(used_r) == int'(cnt_r))
  `DLLE_ASSERT(a_count_in_range, clk, rst_n, cnt_r <= CW'(CAPACITY))
  `DLLE_ASSERT_IMP(a_empty_ends_zero, clk, rst_n, cnt_r == '0, head_r == '0 && tail_r == '0)
  `DLLE_ASSERT_IMP(a_open_beat_walks, clk, rst_n, out_valid_r && !out_last_r, state_r == S_WALK)

endmodule

`default_nettype wire

// File: tb/sv/dlle_checker.sv
// Scoreboard for the doubly linked list engine: watches both channels, keeps its own
// copy of the slot pool and links, and compares every out beat with its prediction.
// Depends on dlle_pkg for field widths, the operation codes and the status codes.
`timescale 1ns / 1ps
`default_nettype none

module dlle_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [dlle_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [dlle_pkg::VALUE_W-1:0]    in_value,
  input  wire logic [dlle_pkg::HANDLE_W-1:0]   in_node_handle,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [dlle_pkg::VALUE_W-1:0]    out_value_out,
  input  wire logic [dlle_pkg::SLOT_OUT_W-1:0] out_slot_out,
  input  wire logic [dlle_pkg::COUNT_W-1:0]    out_count,
  input  wire logic [dlle_pkg::STATUS_W-1:0]   out_status,
  input  wire logic                            out_last,
  output int                                   fail_count,
  output int                                   pending_beats
);
  import dlle_pkg::*;

  localparam int POOL = CAPACITY_DEF;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [VALUE_W-1:0]    value;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COUNT_W-1:0]    count;
    status_t               status;
    logic                  last;
  } list_beat_t;

  logic [VALUE_W-1:0]  slot_data [POOL];
  logic [HANDLE_W-1:0] next_of [POOL];
  logic [HANDLE_W-1:0] prev_of [POOL];
  logic                slot_busy [POOL];
  logic [HANDLE_W-1:0] head_ptr;
  logic [HANDLE_W-1:0] tail_ptr;
  logic [COUNT_W-1:0]  node_total;

  list_beat_t expected_beats[$];
  int mismatches = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < PRINT_CAP) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  function automatic void expect_beat(input logic [VALUE_W-1:0] value,
                                      input logic [SLOT_OUT_W-1:0] slot,
                                      input status_t status, input logic last);
    list_beat_t b;
    b.value  = value;
    b.slot   = slot;
    b.count  = node_total;
    b.status = status;
    b.last   = last;
    expected_beats.push_back(b);
  endfunction

  function automatic void detach_slot(input logic [HANDLE_W-1:0] s);
    if (node_total <= 1) begin
      head_ptr = '0;
      tail_ptr = '0;
    end else if (s == head_ptr) begin
      head_ptr = next_of[s];
    end else if (s == tail_ptr) begin
      tail_ptr = prev_of[s];
    end else begin
      next_of[prev_of[s]] = next_of[s];
      prev_of[next_of[s]] = prev_of[s];
    end
    slot_busy[s] = 1'b0;
    if (node_total > 0) node_total = node_total - 1'b1;
  endfunction

  function automatic void apply_list_op(input op_t op, input logic [VALUE_W-1:0] value,
                                        input logic [HANDLE_W-1:0] handle);
    int s;
    int n;
    logic [HANDLE_W-1:0] cur;
    logic [VALUE_W-1:0] v;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (node_total >= POOL) begin
          expect_beat('0, '0, STAT_FULL, 1'b1);
        end else begin
          s = 0;
          while (s < POOL - 1 && slot_busy[s]) s++;
          slot_data[s] = value;
          slot_busy[s] = 1'b1;
          next_of[s] = HANDLE_W'(s);
          prev_of[s] = HANDLE_W'(s);
          if (node_total == 0) begin
            head_ptr = HANDLE_W'(s);
            tail_ptr = HANDLE_W'(s);
          end else if (op == OP_INS_FRONT) begin
            prev_of[head_ptr] = HANDLE_W'(s);
            next_of[s] = head_ptr;
            head_ptr = HANDLE_W'(s);
          end else begin
            next_of[tail_ptr] = HANDLE_W'(s);
            prev_of[s] = tail_ptr;
            tail_ptr = HANDLE_W'(s);
          end
          node_total = node_total + 1'b1;
          expect_beat('0, SLOT_OUT_W'(s), STAT_OK, 1'b1);
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (node_total == 0) begin
          expect_beat('0, '0, STAT_EMPTY, 1'b1);
        end else begin
          cur = (op == OP_DEL_HEAD) ? head_ptr : tail_ptr;
          v = slot_data[cur];
          detach_slot(cur);
          expect_beat(v, cur, STAT_OK, 1'b1);
        end
      end
      OP_ERASE: begin
        if (!slot_busy[handle]) begin
          expect_beat('0, '0, STAT_BAD_HANDLE, 1'b1);
        end else begin
          v = slot_data[handle];
          detach_slot(handle);
          expect_beat(v, handle, STAT_OK, 1'b1);
        end
      end
      OP_WALK_FWD, OP_WALK_REV: begin
        if (node_total == 0) begin
          expect_beat('0, '0, STAT_EMPTY, 1'b1);
        end else begin
          n = (node_total < WALK_MAX) ? int'(node_total) : WALK_MAX;
          cur = (op == OP_WALK_FWD) ? head_ptr : tail_ptr;
          for (int i = 0; i < n; i++) begin
            expect_beat(slot_data[cur], cur, STAT_OK, i + 1 == n);
            cur = (op == OP_WALK_FWD) ? next_of[cur] : prev_of[cur];
          end
        end
      end
      default: begin
        for (int i = 0; i < POOL; i++) slot_busy[i] = 1'b0;
        head_ptr = '0;
        tail_ptr = '0;
        node_total = '0;
        expect_beat('0, '0, STAT_OK, 1'b1);
      end
    endcase
  endfunction

  task automatic check_beat();
    list_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing expected", '0, out_value_out);
    end else begin
      want = expected_beats.pop_front();
      if (out_value_out !== want.value) report_mismatch("value_out", want.value, out_value_out);
      if (out_slot_out !== want.slot) report_mismatch("slot_out", want.slot, out_slot_out);
      if (out_count !== want.count) report_mismatch("count", want.count, out_count);
      if (out_status !== want.status) report_mismatch("status", want.status, out_status);
      if (out_last !== want.last) report_mismatch("last", want.last, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL; i++) slot_busy[i] = 1'b0;
      head_ptr = '0;
      tail_ptr = '0;
      node_total = '0;
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) apply_list_op(op_t'(in_mode), in_value, in_node_handle);
    end
    fail_count <= mismatches;
    pending_beats <= expected_beats.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Top of the doubly linked list engine testbench: clock, reset, directed and random
// commands with bursty input and a stalling receiver, a watchdog and the verdict.
// Depends on dlle_pkg, doubly_linked_list_engine and dlle_checker.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import dlle_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic [HANDLE_W-1:0] in_node_handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VALUE_W-1:0] out_value_out;
  logic [SLOT_OUT_W-1:0] out_slot_out;
  logic [COUNT_W-1:0] out_count;
  logic [STATUS_W-1:0] out_status;
  logic out_last;

  int fail_count;
  int pending_beats;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [31:0] stall_word = '1;
  logic [6:0] rx_cycle = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  doubly_linked_list_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_node_handle (in_node_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_out  (out_value_out),
    .out_slot_out   (out_slot_out),
    .out_count      (out_count),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  dlle_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_node_handle (in_node_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_out  (out_value_out),
    .out_slot_out   (out_slot_out),
    .out_count      (out_count),
    .out_status     (out_status),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending_beats  (pending_beats)
  );

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle == '0) begin
      case ($urandom_range(0, 3))
        0: stall_word <= '1;
        1: stall_word <= $urandom;
        2: stall_word <= $urandom | $urandom;
        default: stall_word <= $urandom & $urandom;
      endcase
    end
    out_ready <= stall_word[rx_cycle[4:0]];
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input logic [VALUE_W-1:0] value,
                           input logic [HANDLE_W-1:0] handle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= op;
    in_value <= value;
    in_node_handle <= handle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int ins_pct;
    int rm_pct;
    int walk_pct;
    op_t op;
    logic [VALUE_W-1:0] value;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_DEL_HEAD, '0, '0);
    send_item(OP_DEL_TAIL, '0, '0);
    send_item(OP_WALK_FWD, '0, '0);
    send_item(OP_WALK_REV, '0, '0);
    send_item(OP_ERASE, '0, 4'd0);
    send_item(OP_ERASE, '0, 4'd15);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_INS_FRONT, 32'h7FFF_FFFF, '0);
    send_item(OP_INS_BACK, 32'h8000_0000, '0);
    send_item(OP_INS_FRONT, 32'h0000_0000, '0);
    send_item(OP_INS_BACK, 32'hFFFF_FFFF, 4'd15);
    send_item(OP_WALK_FWD, '0, '0);
    send_item(OP_WALK_REV, '0, '0);
    send_item(OP_ERASE, '0, 4'd0);
    send_item(OP_ERASE, '0, 4'd0);
    send_item(OP_ERASE, '0, 4'd15);
    send_item(OP_DEL_HEAD, '0, '0);
    send_item(OP_DEL_TAIL, '0, '0);
    send_item(OP_ERASE, '0, 4'd1);
    send_item(OP_WALK_FWD, '0, '0);
    send_item(OP_INS_BACK, 32'h5A5A_5A5A, '0);
    send_item(OP_INS_FRONT, 32'hA5A5_A5A5, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_WALK_REV, '0, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0, 1: begin
          ins_pct = 80; rm_pct = 8; walk_pct = 12;
        end
        2: begin
          ins_pct = 45; rm_pct = 30; walk_pct = 22;
        end
        default: begin
          ins_pct = 20; rm_pct = 60; walk_pct = 18;
        end
      endcase
      if (phase == 5 || $urandom_range(0, 3) == 0) wait_for_results();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
          op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
        end else if (r < ins_pct + rm_pct) begin
          case ($urandom_range(0, 2))
            0: op = OP_DEL_HEAD;
            1: op = OP_DEL_TAIL;
            default: op = OP_ERASE;
          endcase
        end else if (r < ins_pct + rm_pct + walk_pct) begin
          op = $urandom_range(0, 1) ? OP_WALK_REV : OP_WALK_FWD;
        end else begin
          op = OP_CLEAR;
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            2: value = 32'h0000_0000;
            default: value = 32'hFFFF_FFFF;
          endcase
        end else begin
          value = $urandom;
        end
        send_item(op, value, HANDLE_W'($urandom_range(0, 15)));
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
